FILE: rtl/p1tem_pkg.sv
// Shared types, widths and helper functions of the P1 triangle element matrix block.
// Depends on nothing; every rtl module but the port-level checker imports it.
package p1tem_pkg;

    localparam int CW   = 32;
    localparam int DIFW = CW + 1;
    localparam int PW   = 2 * DIFW;
    localparam int SW   = PW + 2;
    localparam int MW   = SW;
    localparam int SSH  = 15;
    localparam int NW   = MW + 16;
    localparam int QW   = 32;
    localparam int XW   = MW + QW;
    localparam int MTW  = QW + 2;
    localparam int RSH  = MTW + 1;

    localparam logic [MW-1:0] MASS_OFF_DEN  = MW'(1572864);
    localparam logic [MW-1:0] MASS_DIAG_DEN = MW'(786432);
    localparam int            MASS_OFF_SH   = 19;
    localparam int            MASS_DIAG_SH  = 18;
    localparam logic [MTW-1:0] DIV3_RECIP   = MTW'((64'd1 << RSH) / 3 + 1);
    localparam logic [NW-1:0] MASS_Q_LIM    = {{(NW-QW-2){1'b0}}, 2'b11, {QW{1'b0}}};
    localparam logic [1:0]    LAST_NODE     = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x0;
    } coord_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
        logic       diag;
    } tag_t;

    typedef struct packed {
        tag_t tag;
        logic degen;
        logic neg_s;
        logic neg_m;
    } side_t;

    function automatic logic [MW-1:0] mass_den(input logic diag);
        return diag ? MASS_DIAG_DEN : MASS_OFF_DEN;
    endfunction

    function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                            input logic neg);
        logic [QW-1:0] r;
        if (neg) begin
            if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
            else r = -q;
        end else begin
            if (ovf || q[QW-1]) r = 32'h7FFF_FFFF;
            else r = q;
        end
        return r;
    endfunction

endpackage

FILE: rtl/p1tem_seq.sv
// Node pair sequencer: holds one triangle and issues its nine ordered node pairs.
// Depends on p1tem_pkg.
module p1tem_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    output logic            in_ready,
    input  p1tem_pkg::coord_t in_coord,
    output logic            item_valid,
    output p1tem_pkg::tag_t item_tag,
    output p1tem_pkg::coord_t item_coord
);
    import p1tem_pkg::*;

    logic       busy_reg, busy_next;
    logic [1:0] row_reg, row_next, col_reg, col_next;
    coord_t     coord_reg;
    logic       last_pair, take;

    assign last_pair = (row_reg == LAST_NODE) && (col_reg == LAST_NODE);
    assign in_ready  = adv && (!busy_reg || last_pair);
    assign take      = in_valid && in_ready;

    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (take) begin
            busy_next = 1'b1;
            row_next  = 2'd0;
            col_next  = 2'd0;
        end else if (adv && busy_reg) begin
            if (last_pair) begin
                busy_next = 1'b0;
            end else if (col_reg == LAST_NODE) begin
                col_next = 2'd0;
                row_next = row_reg + 2'd1;
            end else begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= 2'd0;
            col_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
        if (take) begin
            coord_reg <= in_coord;
        end
    end

    assign item_valid    = busy_reg;
    assign item_tag.row  = row_reg;
    assign item_tag.col  = col_reg;
    assign item_tag.last = last_pair;
    assign item_tag.diag = (row_reg == col_reg);
    assign item_coord    = coord_reg;
endmodule

FILE: rtl/p1tem_geom.sv
// Geometry stages: differences, products, sums, then magnitudes and dividends.
// Depends on p1tem_pkg.
module p1tem_geom (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  p1tem_pkg::tag_t    in_tag,
    input  p1tem_pkg::coord_t  in_coord,
    output logic               out_valid,
    output p1tem_pkg::side_t   out_side,
    output logic [p1tem_pkg::NW-1:0] out_num_s,
    output logic [p1tem_pkg::NW-1:0] out_num_m,
    output logic [p1tem_pkg::MW-1:0] out_den
);
    import p1tem_pkg::*;

    logic [3:0] vld_reg;
    tag_t       tag1_reg, tag2_reg, tag3_reg;
    logic signed [DIFW-1:0] gx [3];
    logic signed [DIFW-1:0] gy [3];
    logic signed [DIFW-1:0] gxi_next, gyi_next, gxj_next, gyj_next;
    logic signed [DIFW-1:0] gxi_reg, gyi_reg, gxj_reg, gyj_reg, a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0]   pxx_reg, pyy_reg, pab_reg, pcd_reg;
    logic signed [SW-1:0]   dot_reg, dd_reg;
    logic [MW-1:0]          mdot, mdd;
    side_t                  side_reg;
    logic [NW-1:0]          num_s_reg, num_m_reg;
    logic [MW-1:0]          den_reg;

    function automatic logic signed [DIFW-1:0] diff(input logic signed [CW-1:0] p,
                                                    input logic signed [CW-1:0] q);
        return {p[CW-1], p} - {q[CW-1], q};
    endfunction

    always_comb begin
        gx[0] = diff(in_coord.y1, in_coord.y2);
        gy[0] = diff(in_coord.x2, in_coord.x1);
        gx[1] = diff(in_coord.y2, in_coord.y0);
        gy[1] = diff(in_coord.x0, in_coord.x2);
        gx[2] = diff(in_coord.y0, in_coord.y1);
        gy[2] = diff(in_coord.x1, in_coord.x0);
        gxi_next = gx[0];
        gyi_next = gy[0];
        gxj_next = gx[0];
        gyj_next = gy[0];
        if (in_tag.row == 2'd1) begin
            gxi_next = gx[1];
            gyi_next = gy[1];
        end else if (in_tag.row == LAST_NODE) begin
            gxi_next = gx[2];
            gyi_next = gy[2];
        end
        if (in_tag.col == 2'd1) begin
            gxj_next = gx[1];
            gyj_next = gy[1];
        end else if (in_tag.col == LAST_NODE) begin
            gxj_next = gx[2];
            gyj_next = gy[2];
        end
    end

    assign mdot = dot_reg[SW-1] ? MW'(-dot_reg) : MW'(dot_reg);
    assign mdd  = dd_reg[SW-1] ? MW'(-dd_reg) : MW'(dd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
        if (adv) begin
            tag1_reg <= in_tag;
            gxi_reg  <= gxi_next;
            gyi_reg  <= gyi_next;
            gxj_reg  <= gxj_next;
            gyj_reg  <= gyj_next;
            a_reg    <= diff(in_coord.x1, in_coord.x0);
            b_reg    <= diff(in_coord.y2, in_coord.y0);
            c_reg    <= diff(in_coord.x2, in_coord.x0);
            d_reg    <= diff(in_coord.y1, in_coord.y0);

            tag2_reg <= tag1_reg;
            pxx_reg  <= gxi_reg * gxj_reg;
            pyy_reg  <= gyi_reg * gyj_reg;
            pab_reg  <= a_reg * b_reg;
            pcd_reg  <= c_reg * d_reg;

            tag3_reg <= tag2_reg;
            dot_reg  <= {{2{pxx_reg[PW-1]}}, pxx_reg} + {{2{pyy_reg[PW-1]}}, pyy_reg};
            dd_reg   <= {{2{pab_reg[PW-1]}}, pab_reg} - {{2{pcd_reg[PW-1]}}, pcd_reg};

            side_reg.tag   <= tag3_reg;
            side_reg.degen <= (dd_reg == '0);
            side_reg.neg_s <= dot_reg[SW-1] ^ dd_reg[SW-1];
            side_reg.neg_m <= dd_reg[SW-1];
            num_s_reg <= {1'b0, mdot, SSH'(0)} + {17'b0, mdd[MW-1:1]};
            num_m_reg <= NW'(mdd) + NW'(mass_den(tag3_reg.diag) >> 1);
            den_reg   <= mdd;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_side  = side_reg;
    assign out_num_s = num_s_reg;
    assign out_num_m = num_m_reg;
    assign out_den   = den_reg;
endmodule

FILE: rtl/p1tem_div.sv
// Pipelined restoring divider for the stiffness lane, one quotient bit per stage, beside a
// mass lane that divides by three through a reciprocal product. Depends on p1tem_pkg.
module p1tem_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  p1tem_pkg::side_t   in_side,
    input  logic [p1tem_pkg::NW-1:0] in_num_s,
    input  logic [p1tem_pkg::NW-1:0] in_num_m,
    input  logic [p1tem_pkg::MW-1:0] in_den,
    output logic               out_valid,
    output p1tem_pkg::side_t   out_side,
    output logic [p1tem_pkg::QW-1:0] out_q_s,
    output logic [p1tem_pkg::QW-1:0] out_q_m,
    output logic               out_ovf_s,
    output logic               out_ovf_m
);
    import p1tem_pkg::*;

    logic [QW:0]    vld_reg;
    side_t          side_reg  [QW+1];
    logic [NW-1:0]  rem_s_reg [QW+1];
    logic [QW-1:0]  q_s_reg   [QW+1];
    logic [QW-1:0]  q_m_reg   [QW+1];
    logic [MW-1:0]  den_reg   [QW+1];
    logic           ovf_s_reg [QW+1];
    logic           ovf_m_reg [QW+1];
    logic [NW-1:0]  t_m;
    logic [MTW-1:0] t_m_reg;
    logic [2*MTW-1:0] prod_m;

    assign t_m    = in_side.tag.diag ? (in_num_m >> MASS_DIAG_SH) : (in_num_m >> MASS_OFF_SH);
    assign prod_m = t_m_reg * DIV3_RECIP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
        if (adv) begin
            side_reg[0]  <= in_side;
            rem_s_reg[0] <= in_num_s;
            q_s_reg[0]   <= '0;
            q_m_reg[0]   <= '0;
            den_reg[0]   <= in_den;
            t_m_reg      <= t_m[MTW-1:0];
            ovf_s_reg[0] <= XW'(in_num_s) >= {in_den, QW'(0)};
            ovf_m_reg[0] <= t_m >= MASS_Q_LIM;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic [XW-1:0] rs, ts;
        logic          gs;
        assign rs = XW'(rem_s_reg[s]);
        assign ts = XW'(den_reg[s]) << B;
        assign gs = rs >= ts;
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[s+1]  <= side_reg[s];
                den_reg[s+1]   <= den_reg[s];
                ovf_s_reg[s+1] <= ovf_s_reg[s];
                ovf_m_reg[s+1] <= ovf_m_reg[s];
                rem_s_reg[s+1] <= gs ? NW'(rs - ts) : rem_s_reg[s];
                q_s_reg[s+1]   <= q_s_reg[s] | (QW'(gs) << B);
                q_m_reg[s+1]   <= (s == 0) ? prod_m[RSH +: QW] : q_m_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_side  = side_reg[QW];
    assign out_q_s   = q_s_reg[QW];
    assign out_q_m   = q_m_reg[QW];
    assign out_ovf_s = ovf_s_reg[QW];
    assign out_ovf_m = ovf_m_reg[QW];
endmodule

FILE: rtl/p1_triangle_element_matrices.sv
// A triangle word is taken only while the sequencer is idle or issuing the last pair of the
// previous one; it gives nine result words, one per cycle while the result side does not stall,
// in row-major node pair order. Between it and the first result lie the sequencer register,
// four geometry stages, a range check stage and 32 quotient stages in the divider, and the
// output register. A stall on the result side holds the whole pipeline and loses nothing.
// Top level; depends on p1tem_pkg, p1tem_seq, p1tem_geom and p1tem_div.
module p1_triangle_element_matrices (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // x0, y0, x1, y1, x2, y2
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // row_node, col_node, stiffness, mass, zero fill
    output logic         m_tuser,   // degenerate
    output logic         m_tlast
);
    import p1tem_pkg::*;

    logic          adv, seq_valid, geom_valid, div_valid, ovf_s, ovf_m;
    coord_t        in_coord, seq_coord;
    tag_t          seq_tag;
    side_t         geom_side, div_side;
    logic [NW-1:0] num_s, num_m;
    logic [MW-1:0] den;
    logic [QW-1:0] q_s, q_m;
    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;
    logic          m_tuser_reg, m_tlast_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign in_coord = s_tdata;

    p1tem_seq u_seq (
        .aclk, .aresetn, .adv,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_coord,
        .item_valid(seq_valid), .item_tag(seq_tag), .item_coord(seq_coord)
    );

    p1tem_geom u_geom (
        .aclk, .aresetn, .adv,
        .in_valid(seq_valid), .in_tag(seq_tag), .in_coord(seq_coord),
        .out_valid(geom_valid), .out_side(geom_side),
        .out_num_s(num_s), .out_num_m(num_m), .out_den(den)
    );

    p1tem_div u_div (
        .aclk, .aresetn, .adv,
        .in_valid(geom_valid), .in_side(geom_side),
        .in_num_s(num_s), .in_num_m(num_m), .in_den(den),
        .out_valid(div_valid), .out_side(div_side),
        .out_q_s(q_s), .out_q_m(q_m), .out_ovf_s(ovf_s), .out_ovf_m(ovf_m)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
        if (adv) begin
            m_tdata_reg <= {4'b0,
                            div_side.degen ? QW'(0) : sat_q(q_m, ovf_m, div_side.neg_m),
                            div_side.degen ? QW'(0) : sat_q(q_s, ovf_s, div_side.neg_s),
                            div_side.tag.col, div_side.tag.row};
            m_tuser_reg <= div_side.degen;
            m_tlast_reg <= div_side.tag.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
endmodule

FILE: rtl/p1tem_chk.sv
// Port-level checker for the P1 triangle element matrix block, bound to the top level.
// Depends only on the top level's ports.
module p1tem_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid straight after reset");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[67:4] == 64'd0)
        else $error("degenerate triangle with nonzero values");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[1:0] == 2'd2 && m_tdata[3:2] == 2'd2))
        else $error("last flag does not match the final node pair");

    a_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("triangle words taken on consecutive cycles");
endmodule

bind p1_triangle_element_matrices p1tem_chk u_chk (.*);

FILE: tb/tb.sv
// Testbench for p1_triangle_element_matrices: random and directed triangles are offered on the
// input stream and every result word is checked against a bit-exact predictor held here.
// Depends on the rtl package p1tem_pkg and the rtl of the block.
`timescale 1ns / 1ps

module tb;
    import p1tem_pkg::*;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] stiff;
        logic [31:0] mass;
        logic        degen;
        logic        last;
    } elem_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    coord_t pending_tris[$];
    elem_t  expected_elems[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles = 400;
    int     mismatches = 0;

    p1_triangle_element_matrices i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] round_quot(logic signed [127:0] num,
                                               logic signed [127:0] den, int shift);
        logic        neg;
        logic [127:0] mn, md, q;
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        mn = mn << shift;
        q = (mn + (md >> 1)) / md;
        if (neg) begin
            if (q > 128'h8000_0000) return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    task automatic predict_elements(coord_t t);
        logic signed [127:0] d, dot;
        logic signed [127:0] gx[3], gy[3];
        logic signed [127:0] x0, y0, x1, y1, x2, y2;
        elem_t e;
        x0 = t.x0; y0 = t.y0; x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2;
        d = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
        gx[0] = y1 - y2; gy[0] = x2 - x1;
        gx[1] = y2 - y0; gy[1] = x0 - x2;
        gx[2] = y0 - y1; gy[2] = x1 - x0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e.row = i[1:0];
                e.col = j[1:0];
                e.degen = (d == 0);
                e.last = (i == 2 && j == 2);
                e.stiff = '0;
                e.mass = '0;
                if (d != 0) begin
                    dot = gx[i] * gx[j] + gy[i] * gy[j];
                    e.stiff = round_quot(dot, d, SSH);
                    e.mass = round_quot(d, (i == j) ? 128'sd786432 : 128'sd1572864, 0);
                end
                expected_elems.push_back(e);
            end
        end
    endtask

    always @(posedge aclk) begin
        logic nv;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_elements(coord_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                nv = 1'b0;
                if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nv = 1'b1;
                    s_tdata <= pending_tris.pop_front();
                end
                s_tvalid <= nv;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(posedge aclk) begin
        elem_t e;
        if (aresetn) begin
            m_tready <= (hold_cycles <= 1) && ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (expected_elems.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("tb: unexpected result word %h", m_tdata);
                end else begin
                    e = expected_elems.pop_front();
                    if (m_tdata[1:0] !== e.row || m_tdata[3:2] !== e.col ||
                        m_tdata[35:4] !== e.stiff || m_tdata[67:36] !== e.mass ||
                        m_tdata[71:68] !== 4'd0 || m_tuser !== e.degen ||
                        m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: mismatch exp %0d %0d %h %h %b %b got %0d %0d %h %h %b %b",
                                     e.row, e.col, e.stiff, e.mass, e.degen, e.last,
                                     m_tdata[1:0], m_tdata[3:2], m_tdata[35:4],
                                     m_tdata[67:36], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    function automatic coord_t rand_triangle();
        coord_t t;
        int     kind;
        kind = $urandom_range(99);
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 60) begin
            t.x0 = $signed($urandom) >>> 10; t.y0 = $signed($urandom) >>> 10;
            t.x1 = $signed($urandom) >>> 10; t.y1 = $signed($urandom) >>> 10;
            t.x2 = $signed($urandom) >>> 10; t.y2 = $signed($urandom) >>> 10;
        end else if (kind < 70) begin
            t.x2 = t.x1; t.y2 = t.y1;
        end else if (kind < 80) begin
            t.x1 = t.x0 + $signed($urandom_range(255) - 128);
            t.y1 = t.y0 + $signed($urandom_range(255) - 128);
            t.x2 = t.x0 + $signed($urandom_range(255) - 128);
            t.y2 = t.y0 + $signed($urandom_range(255) - 128);
        end
        return t;
    endfunction

    initial begin
        int sidle[4] = '{0, 86, 0, 13};
        int ridle[4] = '{0, 0, 86, 13};
        coord_t t;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        pending_tris.push_back('0);
        pending_tris.push_back({32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0});
        pending_tris.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0});
        pending_tris.push_back({32'sh30000, 32'sh30000, 32'sh20000, 32'sh20000,
                                32'sh10000, 32'sh10000});
        pending_tris.push_back({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                                32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000});
        pending_tris.push_back({32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000});
        pending_tris.push_back({32'sh1, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0});
        pending_tris.push_back({32'sh0, 32'sh1, 32'sh1, 32'sh0, 32'sh0, 32'sh0});
        pending_tris.push_back({32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000});
        pending_tris.push_back({32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF,
                                32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF});
        pending_tris.push_back({32'sh7FFFFFFF, 32'sh0, 32'sh0, 32'sh7FFFFFFF,
                                32'sh0, 32'sh0});
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = sidle[p];
            recv_stall_pct = ridle[p];
            for (int n = 0; n < 65; n++) begin
                t = rand_triangle();
                pending_tris.push_back(t);
            end
            do @(negedge aclk);
            while (pending_tris.size() != 0 || s_tvalid || expected_elems.size() != 0);
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_elems.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
